>>> rtl/cpts_pkg.sv
package cpts_pkg;

    localparam int ID_W         = 6;
    localparam int DUR_W        = 32;
    localparam int TIME_W       = 40;
    localparam int OP_W         = 2;
    localparam int ID_SPACE     = 64;
    localparam int TASK_ENTRY_W = ID_W + DUR_W;
    localparam int EDGE_ENTRY_W = 2 * ID_W + 1;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 88;
    localparam int MAX_TASKS_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_TASK = 2'd0,
        OP_LOAD_EDGE = 2'd1,
        OP_RUN       = 2'd2
    } op_t;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'b00000000000000001,
        ST_INIT_RD  = 17'b00000000000000010,
        ST_INIT_WR  = 17'b00000000000000100,
        ST_BLK_RD   = 17'b00000000000001000,
        ST_BLK_CHK  = 17'b00000000000010000,
        ST_PICK_RD  = 17'b00000000000100000,
        ST_PICK_CHK = 17'b00000000001000000,
        ST_FIN_RD   = 17'b00000000010000000,
        ST_FIN_WR   = 17'b00000000100000000,
        ST_SUCC_RD  = 17'b00000001000000000,
        ST_SUCC_CHK = 17'b00000010000000000,
        ST_SUCC_UPD = 17'b00000100000000000,
        ST_MAK_RD   = 17'b00001000000000000,
        ST_MAK_CHK  = 17'b00010000000000000,
        ST_SEL_RD   = 17'b00100000000000000,
        ST_SEL_CHK  = 17'b01000000000000000,
        ST_EMIT     = 17'b10000000000000000
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - DUR_W){1'b0}}, b};
        return s[TIME_W] ? TIME_SAT : s[TIME_W-1:0];
    endfunction

endpackage

>>> rtl/cpts_ram.sv
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/critical_path_task_scheduler_unit.sv
// Operation: a run walks the task and edge tables to fill in finish times, then
// makes a makespan pass and, for each result, a selection pass and its output, all
// through the single-port table memories.
// Throughput: one load item per cycle while idle; one run item at a time.
// Reset: asynchronous active-low rst_n clears counts, masks and the state
// machine; table memories keep their contents and need no clearing pass.
module critical_path_task_scheduler_unit
    import cpts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op, task_id, duration, edge_from, edge_to
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_task, finish_time, makespan, cycle_error
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // entry_valid
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int TAW = $clog2(MAX_TASKS);
    localparam int TCW = $clog2(MAX_TASKS + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    logic [OP_W-1:0]  in_op;
    logic [ID_W-1:0]  in_id;
    logic [DUR_W-1:0] in_dur;
    logic [ID_W-1:0]  in_from;
    logic [ID_W-1:0]  in_to;

    assign in_op   = s_axis_tdata[1:0];
    assign in_id   = s_axis_tdata[7:2];
    assign in_dur  = s_axis_tdata[39:8];
    assign in_from = s_axis_tdata[45:40];
    assign in_to   = s_axis_tdata[51:46];

    state_t                state_reg, state_next;
    logic [TCW-1:0]        task_count_reg, task_count_next;
    logic [ECW-1:0]        edge_count_reg, edge_count_next;
    logic [ID_SPACE-1:0]   present_reg, present_next;
    logic [ID_SPACE-1:0]   done_reg, done_next;
    logic [ID_SPACE-1:0]   blocked_reg, blocked_next;
    logic [TCW-1:0]        processed_reg, processed_next;
    logic                  cycle_reg, cycle_next;

    logic [TCW-1:0]        s_reg, s_next;
    logic [ECW-1:0]        e_reg, e_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [ID_W-1:0]       cur_id_reg, cur_id_next;
    logic [DUR_W-1:0]      cur_dur_reg, cur_dur_next;
    logic [TIME_W-1:0]     cur_fin_reg, cur_fin_next;
    logic [ID_W-1:0]       succ_id_reg, succ_id_next;
    logic [TIME_W-1:0]     mk_reg, mk_next;
    logic [ID_W-1:0]       best_id_reg, best_id_next;
    logic [TIME_W-1:0]     best_fin_reg, best_fin_next;
    logic                  best_found_reg, best_found_next;
    logic [TCW-1:0]        emit_cnt_reg, emit_cnt_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;

    logic                     task_we;
    logic [TAW-1:0]           task_addr;
    logic [TASK_ENTRY_W-1:0]  task_wdata;
    logic [TASK_ENTRY_W-1:0]  task_rdata;
    logic                     edge_we;
    logic [EAW-1:0]           edge_addr;
    logic [EDGE_ENTRY_W-1:0]  edge_wdata;
    logic [EDGE_ENTRY_W-1:0]  edge_rdata;
    logic                     fin_we;
    logic [ID_W-1:0]          fin_addr;
    logic [TIME_W-1:0]        fin_wdata;
    logic [TIME_W-1:0]        fin_rdata;

    logic                     in_fire;
    logic [ID_W-1:0]          task_rid;
    logic [TIME_W-1:0]        fin_sum;
    logic                     sel_take;
    logic [ID_W-1:0]          sel_id;
    logic [TIME_W-1:0]        sel_fin;

    cpts_ram #(.WIDTH(TASK_ENTRY_W), .DEPTH(MAX_TASKS), .AW(TAW)) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .addr  (task_addr),
        .wdata (task_wdata),
        .rdata (task_rdata)
    );

    cpts_ram #(.WIDTH(EDGE_ENTRY_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (edge_wdata),
        .rdata (edge_rdata)
    );

    cpts_ram #(.WIDTH(TIME_W), .DEPTH(ID_SPACE), .AW(ID_W)) u_fin_ram (
        .clk   (clk),
        .we    (fin_we),
        .addr  (fin_addr),
        .wdata (fin_wdata),
        .rdata (fin_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign task_rid      = task_rdata[TASK_ENTRY_W-1:DUR_W];
    assign fin_sum       = sat_add(fin_rdata, cur_dur_reg);
    assign sel_take      = present_reg[id_reg] && !done_reg[id_reg]
                           && (!best_found_reg || (fin_rdata < best_fin_reg));
    assign sel_id        = sel_take ? id_reg : best_id_reg;
    assign sel_fin       = sel_take ? fin_rdata : best_fin_reg;

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        task_we    = 1'b0;
        task_addr  = s_reg[TAW-1:0];
        task_wdata = {in_id, in_dur};
        edge_we    = 1'b0;
        edge_addr  = e_reg[EAW-1:0];
        edge_wdata = '0;
        fin_we     = 1'b0;
        fin_addr   = cur_id_reg;
        fin_wdata  = cur_fin_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                task_addr  = task_count_reg[TAW-1:0];
                edge_addr  = edge_count_reg[EAW-1:0];
                edge_wdata = {1'b1, in_from, in_to};
                if (in_fire && (in_op == OP_LOAD_TASK) && !present_reg[in_id]
                    && (task_count_reg < TCW'(MAX_TASKS)))
                begin
                    task_we = 1'b1;
                end
                if (in_fire && (in_op == OP_LOAD_EDGE) && present_reg[in_from]
                    && present_reg[in_to] && (edge_count_reg < ECW'(MAX_EDGES)))
                begin
                    edge_we = 1'b1;
                end
            end
            ST_INIT_WR:
            begin
                fin_addr  = task_rid;
                fin_we    = 1'b1;
                fin_wdata = '0;
            end
            ST_FIN_WR:
            begin
                fin_we    = 1'b1;
                fin_wdata = fin_sum;
            end
            ST_SUCC_CHK:
            begin
                fin_addr = edge_rdata[ID_W-1:0];
                if (edge_rdata[EDGE_ENTRY_W-1]
                    && (edge_rdata[2*ID_W-1:ID_W] == cur_id_reg))
                begin
                    edge_we = 1'b1;
                end
            end
            ST_SUCC_UPD:
            begin
                fin_addr  = succ_id_reg;
                fin_we    = (fin_rdata < cur_fin_reg);
                fin_wdata = cur_fin_reg;
            end
            ST_MAK_RD, ST_MAK_CHK, ST_SEL_RD, ST_SEL_CHK:
            begin
                fin_addr = id_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        task_count_next = task_count_reg;
        edge_count_next = edge_count_reg;
        present_next    = present_reg;
        done_next       = done_reg;
        blocked_next    = blocked_reg;
        processed_next  = processed_reg;
        cycle_next      = cycle_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        id_next         = id_reg;
        cur_id_next     = cur_id_reg;
        cur_dur_next    = cur_dur_reg;
        cur_fin_next    = cur_fin_reg;
        succ_id_next    = succ_id_reg;
        mk_next         = mk_reg;
        best_id_next    = best_id_reg;
        best_fin_next   = best_fin_reg;
        best_found_next = best_found_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (task_we)
                begin
                    present_next[in_id] = 1'b1;
                    task_count_next     = task_count_reg + TCW'(1);
                end
                if (edge_we)
                begin
                    edge_count_next = edge_count_reg + ECW'(1);
                end
                if (in_fire && (in_op == OP_RUN))
                begin
                    cycle_next     = 1'b0;
                    done_next      = '0;
                    processed_next = '0;
                    emit_cnt_next  = '0;
                    s_next         = '0;
                    if (task_count_reg == '0)
                    begin
                        out_data_next  = '0;
                        out_valid_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_INIT_RD;
                    end
                end
            end
            ST_INIT_RD:
            begin
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR:
            begin
                s_next = s_reg + TCW'(1);
                if (s_reg + TCW'(1) == task_count_reg)
                begin
                    blocked_next = '0;
                    e_next       = '0;
                    s_next       = '0;
                    state_next   = (edge_count_reg == '0) ? ST_PICK_RD : ST_BLK_RD;
                end
                else
                begin
                    state_next = ST_INIT_RD;
                end
            end
            ST_BLK_RD:
            begin
                state_next = ST_BLK_CHK;
            end
            ST_BLK_CHK:
            begin
                if (edge_rdata[EDGE_ENTRY_W-1])
                begin
                    blocked_next[edge_rdata[ID_W-1:0]] = 1'b1;
                end
                e_next = e_reg + ECW'(1);
                if (e_reg + ECW'(1) == edge_count_reg)
                begin
                    s_next     = '0;
                    state_next = ST_PICK_RD;
                end
                else
                begin
                    state_next = ST_BLK_RD;
                end
            end
            ST_PICK_RD:
            begin
                state_next = ST_PICK_CHK;
            end
            ST_PICK_CHK:
            begin
                if (!done_reg[task_rid] && !blocked_reg[task_rid])
                begin
                    cur_id_next  = task_rid;
                    cur_dur_next = task_rdata[DUR_W-1:0];
                    state_next   = ST_FIN_RD;
                end
                else if (s_reg + TCW'(1) == task_count_reg)
                begin
                    cycle_next = 1'b1;
                    mk_next    = '0;
                    id_next    = '0;
                    state_next = ST_MAK_RD;
                end
                else
                begin
                    s_next     = s_reg + TCW'(1);
                    state_next = ST_PICK_RD;
                end
            end
            ST_FIN_RD:
            begin
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                cur_fin_next         = fin_sum;
                done_next[cur_id_reg] = 1'b1;
                processed_next       = processed_reg + TCW'(1);
                e_next               = '0;
                state_next           = (edge_count_reg == '0) ? ST_SUCC_UPD : ST_SUCC_RD;
                if (edge_count_reg == '0)
                begin
                    succ_id_next = cur_id_reg;
                end
            end
            ST_SUCC_RD:
            begin
                state_next = ST_SUCC_CHK;
            end
            ST_SUCC_CHK, ST_SUCC_UPD:
            begin
                if ((state_reg == ST_SUCC_CHK) && edge_we)
                begin
                    succ_id_next = edge_rdata[ID_W-1:0];
                    state_next   = ST_SUCC_UPD;
                end
                else if ((edge_count_reg == '0) || (e_reg + ECW'(1) == edge_count_reg))
                begin
                    if (processed_reg == task_count_reg)
                    begin
                        mk_next    = '0;
                        id_next    = '0;
                        state_next = ST_MAK_RD;
                    end
                    else
                    begin
                        blocked_next = '0;
                        e_next       = '0;
                        s_next       = '0;
                        state_next   = (edge_count_reg == '0) ? ST_PICK_RD : ST_BLK_RD;
                    end
                end
                else
                begin
                    e_next     = e_reg + ECW'(1);
                    state_next = ST_SUCC_RD;
                end
            end
            ST_MAK_RD:
            begin
                state_next = ST_MAK_CHK;
            end
            ST_MAK_CHK:
            begin
                if (present_reg[id_reg] && (fin_rdata > mk_reg))
                begin
                    mk_next = fin_rdata;
                end
                id_next = id_reg + ID_W'(1);
                if (id_reg == ID_W'(ID_SPACE - 1))
                begin
                    done_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_SEL_RD;
                end
                else
                begin
                    state_next = ST_MAK_RD;
                end
            end
            ST_SEL_RD:
            begin
                state_next = ST_SEL_CHK;
            end
            ST_SEL_CHK:
            begin
                best_id_next  = sel_id;
                best_fin_next = sel_fin;
                if (sel_take)
                begin
                    best_found_next = 1'b1;
                end
                id_next = id_reg + ID_W'(1);
                if (id_reg == ID_W'(ID_SPACE - 1))
                begin
                    out_data_next   = {1'b0, cycle_reg, mk_reg, sel_fin, sel_id};
                    out_valid_next  = 1'b1;
                    out_last_next   = (emit_cnt_reg + TCW'(1) == task_count_reg);
                    done_next[sel_id] = 1'b1;
                    emit_cnt_next   = emit_cnt_reg + TCW'(1);
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if (out_last_reg)
                    begin
                        present_next    = '0;
                        done_next       = '0;
                        task_count_next = '0;
                        edge_count_next = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        id_next         = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            task_count_reg <= '0;
            edge_count_reg <= '0;
            present_reg    <= '0;
            done_reg       <= '0;
            blocked_reg    <= '0;
            processed_reg  <= '0;
            cycle_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            task_count_reg <= task_count_next;
            edge_count_reg <= edge_count_next;
            present_reg    <= present_next;
            done_reg       <= done_next;
            blocked_reg    <= blocked_next;
            processed_reg  <= processed_next;
            cycle_reg      <= cycle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        e_reg          <= e_next;
        id_reg         <= id_next;
        cur_id_reg     <= cur_id_next;
        cur_dur_reg    <= cur_dur_next;
        cur_fin_reg    <= cur_fin_next;
        succ_id_reg    <= succ_id_next;
        mk_reg         <= mk_next;
        best_id_reg    <= best_id_next;
        best_fin_reg   <= best_fin_next;
        best_found_reg <= best_found_next;
        emit_cnt_reg   <= emit_cnt_next;
        out_data_reg   <= out_data_next;
        out_valid_reg  <= out_valid_next;
        out_last_reg   <= out_last_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides active together");

    a_task_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count_reg <= TCW'(MAX_TASKS))
        else $error("task count beyond table depth");

    a_emit_present: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> present_reg[m_axis_tdata[ID_W-1:0]])
        else $error("emitted task not loaded");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty run result not marked last");

endmodule
